// ===== rtl/sdw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sdw_pkg;

    localparam int DATA_W      = 64;
    localparam int DIST_W      = 48;
    localparam int CFG_IDX_W   = 3;

    // latency of one fixed-point multiplier
    localparam int MUL_LAT     = 3;
    // result queue depth, power of two
    localparam int FIFO_DEPTH  = 32;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_INNER_RADIUS  = 3'd0;
    localparam cfg_idx_t REG_CUTOFF_RADIUS = 3'd1;
    localparam cfg_idx_t REG_COEF_ZERO     = 3'd2;
    localparam cfg_idx_t REG_COEF_SQUARE   = 3'd3;
    localparam cfg_idx_t REG_COEF_FOURTH   = 3'd4;
    localparam cfg_idx_t REG_COEF_SIXTH    = 3'd5;
    localparam cfg_idx_t REG_INVERSE_NORM  = 3'd6;

    typedef logic [4:0] factor_t;

    localparam factor_t FACTOR_2  = 5'd2;
    localparam factor_t FACTOR_4  = 5'd4;
    localparam factor_t FACTOR_6  = 5'd6;
    localparam factor_t FACTOR_12 = 5'd12;
    localparam factor_t FACTOR_30 = 5'd30;

    localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // packed so that weight sits in the low bits of tdata
    typedef struct packed {
        logic signed [DATA_W-1:0] curvature;
        logic signed [DATA_W-1:0] slope;
        logic signed [DATA_W-1:0] weight;
    } result_t;

    function automatic logic signed [DATA_W-1:0] sat_add(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        logic signed [DATA_W:0] s;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1])
            return s[DATA_W] ? SAT_MIN : SAT_MAX;
        return s[DATA_W-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_times(
        input logic signed [DATA_W-1:0] a,
        input factor_t                  k
    );
        logic signed [DATA_W+5:0] p;
        p = (DATA_W+6)'(a) * (DATA_W+6)'($signed({1'b0, k}));
        if (p[DATA_W+5:DATA_W-1] != {7{p[DATA_W-1]}})
            return p[DATA_W+5] ? SAT_MIN : SAT_MAX;
        return p[DATA_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/sdw_delay.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sdw_delay #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 3
) (
    input  wire logic             clk,
    input  wire logic [WIDTH-1:0] din,
    output logic      [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        tap_reg[0] <= din;
        for (int i = 1; i < DEPTH; i++)
        begin
            tap_reg[i] <= tap_reg[i-1];
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

`default_nettype wire

// ===== rtl/sdw_fxmul.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Saturating signed fixed-point multiply, three register stages:
// sign/magnitude, four 32x32 partials, recombine + shift + saturate.
module sdw_fxmul
    import sdw_pkg::*;
#(
    parameter int FRAC_BITS = 40
) (
    input  wire logic                     clk,
    input  wire logic signed [DATA_W-1:0] a,
    input  wire logic signed [DATA_W-1:0] b,
    output logic signed      [DATA_W-1:0] p
);

    localparam int HALF_W = DATA_W / 2;
    localparam int PROD_W = 2 * DATA_W;

    logic [DATA_W-1:0] ma_reg, mb_reg;
    logic              neg_a_reg;
    logic [DATA_W-1:0] ll_reg, lh_reg, hl_reg, hh_reg;
    logic              neg_b_reg;
    logic signed [DATA_W-1:0] p_reg;

    logic [DATA_W-1:0] ma_next, mb_next;
    logic [PROD_W-1:0] prod;
    logic              ovf;
    logic [DATA_W-1:0] q;
    logic signed [DATA_W-1:0] p_next;

    always_comb
    begin
        ma_next = a[DATA_W-1] ? (DATA_W'(0) - DATA_W'(a)) : DATA_W'(a);
        mb_next = b[DATA_W-1] ? (DATA_W'(0) - DATA_W'(b)) : DATA_W'(b);
    end

    always_ff @(posedge clk)
    begin
        ma_reg    <= ma_next;
        mb_reg    <= mb_next;
        neg_a_reg <= a[DATA_W-1] ^ b[DATA_W-1];
    end

    always_ff @(posedge clk)
    begin
        ll_reg    <= DATA_W'(ma_reg[HALF_W-1:0])      * DATA_W'(mb_reg[HALF_W-1:0]);
        lh_reg    <= DATA_W'(ma_reg[HALF_W-1:0])      * DATA_W'(mb_reg[DATA_W-1:HALF_W]);
        hl_reg    <= DATA_W'(ma_reg[DATA_W-1:HALF_W]) * DATA_W'(mb_reg[HALF_W-1:0]);
        hh_reg    <= DATA_W'(ma_reg[DATA_W-1:HALF_W]) * DATA_W'(mb_reg[DATA_W-1:HALF_W]);
        neg_b_reg <= neg_a_reg;
    end

    always_comb
    begin
        prod = {hh_reg, ll_reg}
             + {{HALF_W{1'b0}}, lh_reg, {HALF_W{1'b0}}}
             + {{HALF_W{1'b0}}, hl_reg, {HALF_W{1'b0}}};
        ovf  = |prod[PROD_W-1:DATA_W+FRAC_BITS];
        q    = prod[FRAC_BITS +: DATA_W];
        if (!neg_b_reg)
            p_next = (ovf || q[DATA_W-1]) ? SAT_MAX : q;
        else
            p_next = (ovf || q[DATA_W-1]) ? SAT_MIN : (DATA_W'(0) - q);
    end

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// ===== rtl/sdw_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sdw_fifo #(
    parameter int WIDTH = 192,
    parameter int DEPTH = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  rd_valid,
    input  wire logic             rd_ready,
    output logic      [WIDTH-1:0] rd_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             out_valid_reg, out_valid_next;
    logic [WIDTH-1:0] out_data_reg;
    logic             out_free;
    logic             mem_empty;
    logic             bypass;
    logic             mem_wr;
    logic             mem_rd;

    assign rd_valid  = out_valid_reg;
    assign rd_data   = out_data_reg;
    assign out_free  = !out_valid_reg || rd_ready;
    assign mem_empty = (count_reg == '0);
    assign bypass    = wr_en && mem_empty && out_free;
    assign mem_wr    = wr_en && !bypass;
    assign mem_rd    = out_free && !mem_empty;

    always_ff @(posedge clk)
    begin
        if (mem_wr)
            mem[wr_ptr_reg] <= wr_data;
    end

    // output register: loaded from the array, or straight from the write side when empty
    always_ff @(posedge clk)
    begin
        if (mem_rd)
            out_data_reg <= mem[rd_ptr_reg];
        else if (bypass)
            out_data_reg <= wr_data;
    end

    always_comb
    begin
        wr_ptr_next = mem_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = mem_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (mem_wr && !mem_rd)
            count_next = count_reg + 1'b1;
        else if (!mem_wr && mem_rd)
            count_next = count_reg - 1'b1;
        out_valid_next = out_valid_reg;
        if (out_free)
            out_valid_next = mem_rd || bypass;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // upstream credit keeps the queue from ever being written when full
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr |-> (count_reg < CNT_W'(DEPTH)))
        else $error("result queue written while full");

    a_out_first: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> (count_reg == '0))
        else $error("output register empty while queue holds beats");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_valid && !rd_ready) |=> (rd_valid && $stable(rd_data)))
        else $error("output beat changed while stalled");

endmodule

`default_nettype wire

// ===== rtl/shell_density_weight_eval.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Shell density weight evaluator: for each distance beat it returns the weight, slope
// and curvature of the piecewise shell polynomial in one output beat. One distance is
// taken per clock while s_tready is high. A result beat is presented on m_tvalid once
// its accepted distance beat has passed the input register loaded by the accepting edge,
// four dependent rounds of the fixed-point multiplier for the powers and coefficient
// terms, three saturating add stages, one more multiplier round for the normalization,
// and the 32-beat result queue. s_tready stays high while fewer than 32 beats
// are accepted but not yet delivered, so a stalled output side blocks the input once 32
// beats are outstanding; those then settle into the queue. Registers are
// written through cfg_we/cfg_index/cfg_data and must only change while the block
// holds no beat in flight.
module shell_density_weight_eval
    import sdw_pkg::*;
#(
    parameter int FRAC_BITS = 40
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DATA_W-1:0]    cfg_data,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [DIST_W-1:0]    s_tdata,   // distance
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [3*DATA_W-1:0]       m_tdata    // weight, slope, curvature
);

    localparam int TERM_AT  = 4 * MUL_LAT;
    localparam int SUM_AT   = TERM_AT + 3;
    localparam int END_AT   = SUM_AT + MUL_LAT;
    localparam int CREDIT_W = $clog2(FIFO_DEPTH + 1);
    localparam int RES_W    = $bits(result_t);

    // configuration
    logic [DIST_W-1:0]        inner_radius_reg;
    logic [DIST_W-1:0]        cutoff_radius_reg;
    logic signed [DATA_W-1:0] coef_zero_reg;
    logic signed [DATA_W-1:0] coef_square_reg;
    logic signed [DATA_W-1:0] coef_fourth_reg;
    logic signed [DATA_W-1:0] coef_sixth_reg;
    logic signed [DATA_W-1:0] inverse_norm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inner_radius_reg  <= '0;
            cutoff_radius_reg <= DIST_W'(64'd1 << FRAC_BITS);
            coef_zero_reg     <= '0;
            coef_square_reg   <= '0;
            coef_fourth_reg   <= '0;
            coef_sixth_reg    <= '0;
            inverse_norm_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_INNER_RADIUS:  inner_radius_reg  <= cfg_data[DIST_W-1:0];
                REG_CUTOFF_RADIUS: cutoff_radius_reg <= cfg_data[DIST_W-1:0];
                REG_COEF_ZERO:     coef_zero_reg     <= cfg_data;
                REG_COEF_SQUARE:   coef_square_reg   <= cfg_data;
                REG_COEF_FOURTH:   coef_fourth_reg   <= cfg_data;
                REG_COEF_SIXTH:    coef_sixth_reg    <= cfg_data;
                REG_INVERSE_NORM:  inverse_norm_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // handshake and credit
    logic                s_acc, m_acc;
    logic [CREDIT_W-1:0] credit_reg, credit_next;
    logic [END_AT:0]     vld_reg;

    assign s_tready = (credit_reg < CREDIT_W'(FIFO_DEPTH));
    assign s_acc    = s_tvalid && s_tready;
    assign m_acc    = m_tvalid && m_tready;

    always_comb
    begin
        credit_next = credit_reg;
        if (s_acc && !m_acc)
            credit_next = credit_reg + 1'b1;
        else if (!s_acc && m_acc)
            credit_next = credit_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg <= '0;
            vld_reg    <= '0;
        end
        else
        begin
            credit_reg <= credit_next;
            vld_reg    <= {vld_reg[END_AT-1:0], s_acc};
        end
    end

    // input stage: range class is decided here
    logic [DIST_W-1:0] dist_reg;
    logic              below_reg, above_reg;

    always_ff @(posedge clk)
    begin
        dist_reg  <= s_tdata;
        below_reg <= (s_tdata < inner_radius_reg);
        above_reg <= (s_tdata > cutoff_radius_reg);
    end

    logic signed [DATA_W-1:0] r0;
    assign r0 = {{(DATA_W-DIST_W){1'b0}}, dist_reg};

    // round 1
    logic signed [DATA_W-1:0] r2, c2r;
    logic signed [DATA_W-1:0] r_d3, r_d6;

    sdw_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mul_r2  (.clk(clk), .a(r0), .b(r0), .p(r2));
    sdw_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mul_c2r (.clk(clk), .a(coef_square_reg), .b(r0),
                                                  .p(c2r));

    sdw_delay #(.WIDTH(DATA_W), .DEPTH(MUL_LAT)) u_dly_r3 (.clk(clk), .din(r0),
                                                           .dout(r_d3));
    sdw_delay #(.WIDTH(DATA_W), .DEPTH(MUL_LAT)) u_dly_r6 (.clk(clk), .din(r_d3),
                                                           .dout(r_d6));

    // round 2
    logic signed [DATA_W-1:0] r3, r4, c2r2, c4r2, r2_d3;

    sdw_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mul_r3   (.clk(clk), .a(r2), .b(r_d3), .p(r3));
    sdw_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mul_r4   (.clk(clk), .a(r2), .b(r2), .p(r4));
    sdw_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mul_c2r2 (.clk(clk), .a(coef_square_reg), .b(r2),
                                                   .p(c2r2));
    sdw_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mul_c4r2 (.clk(clk), .a(coef_fourth_reg), .b(r2),
                                                   .p(c4r2));

    sdw_delay #(.WIDTH(DATA_W), .DEPTH(MUL_LAT)) u_dly_r2 (.clk(clk), .din(r2),
                                                           .dout(r2_d3));

    // round 3
    logic signed [DATA_W-1:0] r5, r6, c4r4, c4r3, c6r4;

    sdw_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mul_r5   (.clk(clk), .a(r4), .b(r_d6), .p(r5));
    sdw_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mul_r6   (.clk(clk), .a(r4), .b(r2_d3), .p(r6));
    sdw_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mul_c4r4 (.clk(clk), .a(coef_fourth_reg), .b(r4),
                                                   .p(c4r4));
    sdw_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mul_c4r3 (.clk(clk), .a(coef_fourth_reg), .b(r3),
                                                   .p(c4r3));
    sdw_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mul_c6r4 (.clk(clk), .a(coef_sixth_reg), .b(r4),
                                                   .p(c6r4));

    // round 4
    logic signed [DATA_W-1:0] c6r6, c6r5;

    sdw_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mul_c6r6 (.clk(clk), .a(coef_sixth_reg), .b(r6),
                                                   .p(c6r6));
    sdw_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mul_c6r5 (.clk(clk), .a(coef_sixth_reg), .b(r5),
                                                   .p(c6r5));

    // align earlier terms with the last round
    logic signed [DATA_W-1:0] c2r_a, c2r2_a, c4r2_a, c4r4_a, c4r3_a, c6r4_a;

    sdw_delay #(.WIDTH(DATA_W), .DEPTH(3 * MUL_LAT)) u_dly_t1 (.clk(clk), .din(c2r),
                                                               .dout(c2r_a));
    sdw_delay #(.WIDTH(2 * DATA_W), .DEPTH(2 * MUL_LAT)) u_dly_t2 (
        .clk  (clk),
        .din  ({c2r2, c4r2}),
        .dout ({c2r2_a, c4r2_a})
    );
    sdw_delay #(.WIDTH(3 * DATA_W), .DEPTH(MUL_LAT)) u_dly_t3 (
        .clk  (clk),
        .din  ({c4r4, c4r3, c6r4}),
        .dout ({c4r4_a, c4r3_a, c6r4_a})
    );

    // summation, left to right, one saturating add per stage
    logic signed [DATA_W-1:0] w1_reg, wb_reg, wc_reg;
    logic signed [DATA_W-1:0] sa_reg, sb_reg, sc_reg;
    logic signed [DATA_W-1:0] ka_reg, kb_reg, kc_reg;
    logic signed [DATA_W-1:0] w2_reg, wc2_reg, s2_reg, sc2_reg, k2_reg, kc2_reg;
    logic signed [DATA_W-1:0] w3_reg, s3_reg, k3_reg;

    always_ff @(posedge clk)
    begin
        w1_reg  <= sat_add(coef_zero_reg, c2r2_a);
        wb_reg  <= c4r4_a;
        wc_reg  <= c6r6;
        sa_reg  <= sat_times(c2r_a, FACTOR_2);
        sb_reg  <= sat_times(c4r3_a, FACTOR_4);
        sc_reg  <= sat_times(c6r5, FACTOR_6);
        ka_reg  <= sat_times(coef_square_reg, FACTOR_2);
        kb_reg  <= sat_times(c4r2_a, FACTOR_12);
        kc_reg  <= sat_times(c6r4_a, FACTOR_30);

        w2_reg  <= sat_add(w1_reg, wb_reg);
        wc2_reg <= wc_reg;
        s2_reg  <= sat_add(sa_reg, sb_reg);
        sc2_reg <= sc_reg;
        k2_reg  <= sat_add(ka_reg, kb_reg);
        kc2_reg <= kc_reg;

        w3_reg  <= sat_add(w2_reg, wc2_reg);
        s3_reg  <= sat_add(s2_reg, sc2_reg);
        k3_reg  <= sat_add(k2_reg, kc2_reg);
    end

    // normalization
    logic signed [DATA_W-1:0] w_poly, s_poly, k_poly;

    sdw_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mul_wn (.clk(clk), .a(w3_reg),
                                                 .b(inverse_norm_reg), .p(w_poly));
    sdw_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mul_sn (.clk(clk), .a(s3_reg),
                                                 .b(inverse_norm_reg), .p(s_poly));
    sdw_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mul_kn (.clk(clk), .a(k3_reg),
                                                 .b(inverse_norm_reg), .p(k_poly));

    logic below_end, above_end;

    sdw_delay #(.WIDTH(2), .DEPTH(END_AT)) u_dly_class (
        .clk  (clk),
        .din  ({below_reg, above_reg}),
        .dout ({below_end, above_end})
    );

    // inner test wins over the cutoff test
    result_t res;

    always_comb
    begin
        if (below_end)
        begin
            res.weight    = inverse_norm_reg;
            res.slope     = '0;
            res.curvature = '0;
        end
        else if (above_end)
        begin
            res.weight    = '0;
            res.slope     = '0;
            res.curvature = '0;
        end
        else
        begin
            res.weight    = w_poly;
            res.slope     = s_poly;
            res.curvature = k_poly;
        end
    end

    sdw_fifo #(.WIDTH(RES_W), .DEPTH(FIFO_DEPTH)) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (vld_reg[END_AT]),
        .wr_data  (res),
        .rd_valid (m_tvalid),
        .rd_ready (m_tready),
        .rd_data  (m_tdata)
    );

    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        credit_reg <= CREDIT_W'(FIFO_DEPTH))
        else $error("outstanding beat count above queue depth");

    a_credit_cover: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid || vld_reg[END_AT]) |-> (credit_reg != '0))
        else $error("result present with no outstanding beat");

    a_credit_step: assert property (@(posedge clk) disable iff (!rst_n)
        (s_acc && !m_acc) |=> (credit_reg == $past(credit_reg) + 1'b1))
        else $error("credit not advanced on accepted beat");

endmodule

`default_nettype wire
